/* sv/bsas_pkg.sv */
// Package for the block store address sequencer: request and response word
// types and the command/status structs between controller and datapath.
// No dependencies.
package bsas_pkg;

   localparam int unsigned REGISTER_COUNT = 16;
   localparam int unsigned LIST_BITS      = 16;
   localparam int unsigned REG_IDX_BITS   = 4;

   typedef struct packed {
      logic [31:0] instruction_word;
      logic [31:0] base_value;
      logic [1:0]  current_mode;
   } req_word_type;

   typedef struct packed {
      logic        transfer_valid;
      logic [31:0] transfer_address;
      logic [3:0]  source_register;
      logic [1:0]  source_bank;
      logic        dummy_read;
      logic        writeback_valid;
      logic [31:0] writeback_address;
      logic        address_exception;
      logic        last_item;
   } rsp_word_type;

   // controller -> datapath
   typedef struct packed {
      logic load;   // capture a new request word
      logic step;   // build the next response word into the output register
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic last;   // the word built on this step is the final one
   } dp_sts_type;

endpackage

/* sv/block_store_address_sequencer_core.sv */
// Block store address sequencer: one request word (store-multiple instruction,
// base value, mode) yields one response word per set bit of the register list,
// ascending, or a single marker word for an empty list. The request is taken in
// the idle state, then the sequencer emits one response word per cycle, when
// the output register is free, so the next request is taken only after the
// final word is built; the rate is set by the single find-lowest-bit step in
// the datapath. A final word may still wait in the output register while the
// next request is accepted.
// Depends on bsas_pkg, bsas_controller, bsas_datapath.
module block_store_address_sequencer_core #(
   parameter int unsigned ADDRESS_BITS = 26
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  bsas_pkg::req_word_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output bsas_pkg::rsp_word_type rsp_data
);

   bsas_pkg::dp_cmd_type cmd;
   bsas_pkg::dp_sts_type sts;

   bsas_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   bsas_datapath #(
      .ADDRESS_BITS (ADDRESS_BITS)
   ) u_dp (
      .clock    (clock),
      .req_data (req_data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

endmodule

/* sv/bsas_datapath.sv */
// Datapath of the block store address sequencer: working registers for the
// register list and address, and the response output register.
// Depends on bsas_pkg.
module bsas_datapath #(
   parameter int unsigned ADDRESS_BITS = 26
) (
   input  logic                  clock,
   input  bsas_pkg::req_word_type req_data,
   input  bsas_pkg::dp_cmd_type  cmd,
   output bsas_pkg::dp_sts_type  sts,
   output bsas_pkg::rsp_word_type rsp_data
);

   localparam logic [31:0] HighMask = ~((32'd1 << ADDRESS_BITS) - 32'd1);

   localparam logic [2:0] NibbleCount [16] = '{
      3'd0, 3'd1, 3'd1, 3'd2, 3'd1, 3'd2, 3'd2, 3'd3,
      3'd1, 3'd2, 3'd2, 3'd3, 3'd2, 3'd3, 3'd3, 3'd4
   };

   logic [15:0] list_ff, list_in;
   logic [31:0] addr_ff, addr_in;
   logic        exc_ff, exc_in;
   logic        first_ff, first_in;
   logic [1:0]  bank_ff, bank_in;
   logic        wbv_ff, wbv_in;
   logic [31:0] wba_ff, wba_in;
   bsas_pkg::rsp_word_type out_ff, out_in;

   // request decode
   logic [31:0] instr;
   logic [31:0] base;
   logic        pre, up, sbit, wbit;
   logic [3:0]  rn;
   logic [15:0] req_list;
   logic [4:0]  count;
   logic [31:0] len;
   logic [31:0] first_addr;

   // step
   logic [15:0] next_list;
   logic [3:0]  src_idx;
   logic        is_last;
   logic        xfer;

   always_comb begin
      instr    = req_data.instruction_word;
      base     = req_data.base_value;
      pre      = instr[24];
      up       = instr[23];
      sbit     = instr[22];
      wbit     = instr[21];
      rn       = instr[19:16];
      req_list = instr[15:0];
      count    = {2'b00, NibbleCount[req_list[3:0]]}
               + {2'b00, NibbleCount[req_list[7:4]]}
               + {2'b00, NibbleCount[req_list[11:8]]}
               + {2'b00, NibbleCount[req_list[15:12]]};
      len        = {25'd0, count, 2'b00};
      first_addr = base - (up ? 32'd0 : len) + ((up ^ pre) ? 32'd0 : 32'd4);
   end

   // lowest set bit of the remaining list
   always_comb begin
      src_idx = '0;
      for (int i = 15; i >= 0; i--) begin
         if (list_ff[i]) src_idx = 4'(i);
      end
   end

   always_comb begin
      next_list = list_ff & (list_ff - 16'd1);
      is_last   = (next_list == 16'd0);
      xfer      = (list_ff != 16'd0);
      sts.last  = is_last;

      list_in  = list_ff;
      addr_in  = addr_ff;
      exc_in   = exc_ff;
      first_in = first_ff;
      bank_in  = bank_ff;
      wbv_in   = wbv_ff;
      wba_in   = wba_ff;
      out_in   = out_ff;

      if (cmd.load) begin
         list_in  = req_list;
         addr_in  = first_addr;
         exc_in   = ((first_addr & HighMask) != 32'd0);
         first_in = 1'b1;
         bank_in  = sbit ? 2'd0 : req_data.current_mode;
         wbv_in   = wbit && (rn != 4'd15);
         wba_in   = up ? (base + len) : (base - len);
      end else if (cmd.step) begin
         // empty list falls through as the marker word
         out_in.transfer_valid    = xfer;
         out_in.transfer_address  = addr_ff;
         out_in.source_register   = src_idx;
         out_in.source_bank       = bank_ff;
         out_in.dummy_read        = xfer & exc_ff;
         out_in.writeback_valid   = first_ff & wbv_ff;
         out_in.writeback_address = first_ff ? wba_ff : 32'd0;
         out_in.address_exception = is_last & exc_ff;
         out_in.last_item         = is_last;
         list_in  = next_list;
         addr_in  = addr_ff + 32'd4;
         first_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      list_ff  <= list_in;
      addr_ff  <= addr_in;
      exc_ff   <= exc_in;
      first_ff <= first_in;
      bank_ff  <= bank_in;
      wbv_ff   <= wbv_in;
      wba_ff   <= wba_in;
      out_ff   <= out_in;
   end

   assign rsp_data = out_ff;

endmodule

/* sv/bsas_controller.sv */
// Controller of the block store address sequencer: idle/busy state machine
// and response valid register. Depends on bsas_pkg.
module bsas_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output bsas_pkg::dp_cmd_type cmd,
   input  bsas_pkg::dp_sts_type sts
);

   localparam logic StIdle = 1'b0;
   localparam logic StBusy = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   always_comb begin
      req_stall = (state_ff != StIdle);
      out_free  = !rsp_valid_ff || !rsp_stall;
      cmd.load  = 1'b0;
      cmd.step  = 1'b0;
      state_in  = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         StIdle: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = StBusy;
            end
         end
         StBusy: begin
            if (out_free) begin
               cmd.step     = 1'b1;
               rsp_valid_in = 1'b1;
               if (sts.last) state_in = StIdle;
            end
         end
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

/* sv/bsas_checker.sv */
// Port-level checker for block_store_address_sequencer_core, with its bind.
// Depends on bsas_pkg.
module bsas_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input bsas_pkg::rsp_word_type rsp_data
);

   // a taken request always produces at least one word, so the input closes
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted but next request not held off");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response word changed");

   a_marker_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.transfer_valid |-> rsp_data.last_item)
      else $error("empty-list marker not flagged last");

   a_exc_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.address_exception |-> rsp_data.last_item)
      else $error("address exception on a non-final word");

   a_dummy_xfer: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.dummy_read |-> rsp_data.transfer_valid)
      else $error("dummy read on a non-transfer word");

endmodule

bind block_store_address_sequencer_core bsas_checker u_bsas_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

/* bench/tb_top.sv */
// Testbench for block_store_address_sequencer_core: directed and random store-multiple
// words, with a local predictor of the transfer sequence and an in-order checker.
// Depends on bsas_pkg and the core with its controller and datapath.
module tb_top;

   localparam int unsigned ADDR_BITS = 26;

   typedef enum logic [1:0] {MODE_USR, MODE_FIQ, MODE_IRQ, MODE_SVC} cpu_mode_type;

   logic                   clock;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   bsas_pkg::req_word_type req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   bsas_pkg::rsp_word_type rsp_data;

   bsas_pkg::rsp_word_type transfer_q[$];
   int                     err_count  = 0;
   int                     stall_left = 0;
   bit                     bursts_on  = 1'b1;

   block_store_address_sequencer_core #(.ADDRESS_BITS(ADDR_BITS)) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #3000000;
      $display("DONE: errors detected");
      $finish;
   end

   // STM encoding: cond AL, L clear
   function automatic logic [31:0] stm_word(input bit pre, input bit up, input bit sbit,
                                            input bit wbit, input logic [3:0] rn,
                                            input logic [15:0] list);
      return {4'hE, 3'b100, pre, up, sbit, wbit, 1'b0, rn, list};
   endfunction

   function automatic bsas_pkg::req_word_type make_req(input logic [31:0] instr,
                                                       input logic [31:0] base,
                                                       input cpu_mode_type mode);
      bsas_pkg::req_word_type w;
      w.instruction_word = instr;
      w.base_value       = base;
      w.current_mode     = mode;
      return w;
   endfunction

   // Expected transfer words for one store-multiple, queued in order
   function automatic void predict_transfers(input bsas_pkg::req_word_type w);
      logic        pre, up, sbit, wbit, exc, wb_ok, first_done;
      logic [3:0]  rn;
      logic [15:0] list;
      logic [31:0] span, wb_addr, addr;
      logic [1:0]  bank;
      int          count, seen;
      bsas_pkg::rsp_word_type t;
      pre   = w.instruction_word[24];
      up    = w.instruction_word[23];
      sbit  = w.instruction_word[22];
      wbit  = w.instruction_word[21];
      rn    = w.instruction_word[19:16];
      list  = w.instruction_word[15:0];
      count = $countones(list);
      span  = 32'(4 * count);
      wb_addr = up ? w.base_value + span : w.base_value - span;
      addr  = w.base_value - (up ? 32'd0 : span) + ((up ^ pre) ? 32'd0 : 32'd4);
      bank  = sbit ? 2'(MODE_USR) : w.current_mode;
      wb_ok = wbit && (rn != 4'd15);
      exc   = (ADDR_BITS < 32) && ((64'(addr) >> ADDR_BITS) != 0);
      if (list == 16'd0) begin
         t = '0;
         t.transfer_address  = addr;
         t.source_bank       = bank;
         t.writeback_valid   = wb_ok;
         t.writeback_address = wb_addr;
         t.address_exception = exc;
         t.last_item         = 1'b1;
         transfer_q.push_back(t);
         return;
      end
      first_done = 1'b0;
      seen = 0;
      for (int r = 0; r < bsas_pkg::REGISTER_COUNT; r++) begin
         if (list[r]) begin
            seen++;
            t = '0;
            t.transfer_valid    = 1'b1;
            t.transfer_address  = addr;
            t.source_register   = 4'(r);
            t.source_bank       = bank;
            t.dummy_read        = exc;
            t.writeback_valid   = first_done ? 1'b0 : wb_ok;
            t.writeback_address = first_done ? 32'd0 : wb_addr;
            t.address_exception = (seen == count) ? exc : 1'b0;
            t.last_item         = (seen == count);
            transfer_q.push_back(t);
            first_done = 1'b1;
            addr += 32'd4;
         end
      end
   endfunction

   task automatic send_store(input bsas_pkg::req_word_type w);
      if (bursts_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (req_stall);
      predict_transfers(w);
   endtask

   // receiver stall in random bursts, started only while bursts_on is set
   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (bursts_on && $urandom_range(0, 5) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 6);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic report(input string field, input logic [31:0] exp, input logic [31:0] act);
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, exp, act);
      err_count++;
   endtask

   always @(posedge clock) begin
      bsas_pkg::rsp_word_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (transfer_q.size() == 0) begin
            $display("%0t: unexpected word, expected none, actual %h", $time, rsp_data);
            err_count++;
         end else begin
            e = transfer_q.pop_front();
            if (rsp_data.transfer_valid !== e.transfer_valid)
               report("transfer_valid", 32'(e.transfer_valid),
                      32'(rsp_data.transfer_valid));
            if (rsp_data.transfer_address !== e.transfer_address)
               report("transfer_address", e.transfer_address, rsp_data.transfer_address);
            if (rsp_data.source_register !== e.source_register)
               report("source_register", 32'(e.source_register),
                      32'(rsp_data.source_register));
            if (rsp_data.source_bank !== e.source_bank)
               report("source_bank", 32'(e.source_bank), 32'(rsp_data.source_bank));
            if (rsp_data.dummy_read !== e.dummy_read)
               report("dummy_read", 32'(e.dummy_read), 32'(rsp_data.dummy_read));
            if (rsp_data.writeback_valid !== e.writeback_valid)
               report("writeback_valid", 32'(e.writeback_valid),
                      32'(rsp_data.writeback_valid));
            if (rsp_data.writeback_address !== e.writeback_address)
               report("writeback_address", e.writeback_address, rsp_data.writeback_address);
            if (rsp_data.address_exception !== e.address_exception)
               report("address_exception", 32'(e.address_exception),
                      32'(rsp_data.address_exception));
            if (rsp_data.last_item !== e.last_item)
               report("last_item", 32'(e.last_item), 32'(rsp_data.last_item));
         end
      end
   end

   task automatic test_addressing_modes();
      for (int m = 0; m < 4; m++)
         send_store(make_req(stm_word(m[1], m[0], 1'b0, 1'b1, 4'd3, 16'h8421),
                             32'h0000_1000, cpu_mode_type'(m)));
   endtask

   task automatic test_list_extremes();
      send_store(make_req(stm_word(1'b1, 1'b1, 1'b1, 1'b1, 4'd13, 16'hFFFF),
                          32'h0000_8000, MODE_SVC));
      send_store(make_req(stm_word(1'b0, 1'b1, 1'b0, 1'b0, 4'd0, 16'h0001),
                          32'h0123_4564, MODE_FIQ));
      send_store(make_req(stm_word(1'b1, 1'b0, 1'b0, 1'b1, 4'd14, 16'h8000),
                          32'h0000_0400, MODE_IRQ));
   endtask

   task automatic test_empty_list();
      send_store(make_req(stm_word(1'b1, 1'b1, 1'b0, 1'b1, 4'd2, 16'h0000),
                          32'h0000_2000, MODE_USR));
      send_store(make_req(stm_word(1'b0, 1'b0, 1'b1, 1'b1, 4'd2, 16'h0000),
                          32'h0000_2000, MODE_SVC));
      send_store(make_req(stm_word(1'b0, 1'b1, 1'b0, 1'b1, 4'd5, 16'h0000),
                          32'hFC00_0000, MODE_IRQ));
   endtask

   // base R15: write-back never happens, PSR bits may push the address out of range
   task automatic test_base_pc();
      send_store(make_req(stm_word(1'b1, 1'b0, 1'b0, 1'b1, 4'd15, 16'h00F0),
                          32'h03FF_FFFC, MODE_SVC));
      send_store(make_req(stm_word(1'b0, 1'b1, 1'b1, 1'b1, 4'd15, 16'h0C03),
                          32'hF000_0003, MODE_FIQ));
   endtask

   task automatic test_address_exception();
      send_store(make_req(stm_word(1'b1, 1'b1, 1'b0, 1'b1, 4'd4, 16'h0110),
                          32'h03FF_FFFC, MODE_USR));
      send_store(make_req(stm_word(1'b1, 1'b0, 1'b0, 1'b1, 4'd4, 16'h0110),
                          32'h0400_0000, MODE_USR));
      send_store(make_req(stm_word(1'b0, 1'b1, 1'b1, 1'b0, 4'd7, 16'h7001),
                          32'h8000_0000, MODE_IRQ));
   endtask

   task automatic test_address_wrap();
      send_store(make_req(stm_word(1'b1, 1'b0, 1'b0, 1'b1, 4'd1, 16'h00FF),
                          32'h0000_0000, MODE_SVC));
      send_store(make_req(stm_word(1'b1, 1'b1, 1'b0, 1'b1, 4'd1, 16'hF00F),
                          32'hFFFF_FFFC, MODE_USR));
   endtask

   task automatic test_field_extremes();
      send_store(make_req(32'hFFFF_FFFF, 32'hFFFF_FFFF, MODE_SVC));
      send_store(make_req(32'h0000_0000, 32'h0000_0000, MODE_USR));
   endtask

   function automatic bsas_pkg::req_word_type random_store();
      logic [31:0] instr, base;
      logic [15:0] list;
      int          pick;
      instr = $urandom;
      pick  = $urandom_range(0, 9);
      case (pick)
         0: list = 16'h0000;
         1: list = 16'hFFFF;
         2, 3, 4: begin
            list = 16'h1 << $urandom_range(0, 15);
            if ($urandom_range(0, 1)) list |= 16'h1 << $urandom_range(0, 15);
         end
         default: list = 16'($urandom);
      endcase
      pick = $urandom_range(0, 7);
      case (pick)
         0: base = $urandom;
         1: base = 32'h0400_0000 - 32'($urandom_range(0, 80));
         2: base = 32'($urandom_range(0, 80));
         default: base = $urandom & 32'h03FF_FFFF;
      endcase
      if ($urandom_range(0, 7) == 0) instr[19:16] = 4'd15;
      instr[15:0] = list;
      return make_req(instr, base, cpu_mode_type'($urandom_range(0, 3)));
   endfunction

   task automatic test_random_stores();
      for (int i = 0; i < 330; i++) begin
         // some stretches run without any idle cycles
         if (i % 55 == 0) bursts_on <= ((i / 55) % 3 != 2);
         send_store(random_store());
      end
   endtask

   task automatic test_back_to_back();
      bursts_on <= 1'b0;
      for (int i = 0; i < 60; i++)
         send_store(random_store());
      req_valid <= 1'b0;
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_addressing_modes();
      test_list_extremes();
      test_empty_list();
      test_base_pc();
      test_address_exception();
      test_address_wrap();
      test_field_extremes();
      test_random_stores();
      test_back_to_back();
      while (transfer_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (err_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
